// File: src/hcsc_pkg.sv
package hcsc_pkg;

   // Field widths fixed by the port list
   localparam int IN_KEY_BITS  = 64;
   localparam int IN_DATA_BITS = 32;
   localparam int OFFER_BITS   = 15;
   localparam int FOUND_BITS   = 32;

   // Hit counts are signed so that the reset ramp 0, -1, -2 ... sorts no higher than any offer
   localparam int COUNT_BITS = 16;
   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = 16'sd32767;
   localparam logic signed [COUNT_BITS-1:0] COUNT_ONE = 16'sd1;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_OFFER  = 1'b1
   } op_type;

endpackage

// File: src/hcsc_mem.sv
module hcsc_mem
   import hcsc_pkg::*;
#(
   parameter int DEPTH     = 10,
   parameter int KEY_BITS  = 64,
   parameter int DATA_BITS = 32,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_BITS-1:0]         wr_addr,
   input  logic [KEY_BITS-1:0]          wr_key,
   input  logic [DATA_BITS-1:0]         wr_data,
   input  logic signed [COUNT_BITS-1:0] wr_count,
   input  logic                         rd_en,
   input  logic [ADDR_BITS-1:0]         rd_addr,
   output logic [KEY_BITS-1:0]          rd_key,
   output logic [DATA_BITS-1:0]         rd_data,
   output logic signed [COUNT_BITS-1:0] rd_count
);

   logic [KEY_BITS-1:0]          key_mem   [DEPTH];
   logic [DATA_BITS-1:0]         data_mem  [DEPTH];
   logic signed [COUNT_BITS-1:0] count_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         data_mem[wr_addr]  <= wr_data;
         count_mem[wr_addr] <= wr_count;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key   <= key_mem[rd_addr];
         rd_data  <= data_mem[rd_addr];
         rd_count <= count_mem[rd_addr];
      end
   end

endmodule

// File: src/hit_count_sorted_cache_top.sv
// Response: rsp_valid rises after the search of all entries and the decision for a miss or an
//   offer that is not taken; for a hit or a taken offer, after the entries between the old and
//   the new place are shifted down and the entry is written. The next start is taken in the strobe cycle.
// A new request is taken only once the last one is done; the search and the shift go one entry
//   per cycle over the single read port of the entry memory.
// Reset: a clearing pass over all entries with busy high; the receiver cannot stall.
module hit_count_sorted_cache_top
   import hcsc_pkg::*;
#(
   parameter int CACHE_ENTRIES = 10,
   parameter int KEY_BITS      = 64,
   parameter int DATA_BITS     = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic [IN_KEY_BITS-1:0]  req_key,
   input  logic [IN_DATA_BITS-1:0] req_entry_data,
   input  logic [OFFER_BITS-1:0]   req_offered_count,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic [FOUND_BITS-1:0]   rsp_found_data,
   output logic                    rsp_replaced
);

   localparam int IDX_BITS = $clog2(CACHE_ENTRIES);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CACHE_ENTRIES - 1);
   // Common width for moving data between the ports and the stored width
   localparam int IN_WIDE_BITS  = (DATA_BITS > IN_DATA_BITS) ? DATA_BITS : IN_DATA_BITS;
   localparam int OUT_WIDE_BITS = (DATA_BITS > FOUND_BITS) ? DATA_BITS : FOUND_BITS;

   // Clear the memory, wait, search all entries, decide, shift entries down, write the entry
   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_MOVE   = 6'b010000,
      ST_PLACE  = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_BITS-1:0]          idx_ff, idx_in;
   op_type                       op_ff, op_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic [DATA_BITS-1:0]         data_ff, data_in;
   logic [OFFER_BITS-1:0]        offered_ff, offered_in;
   logic                         found_ff, found_in;
   logic [IDX_BITS-1:0]          src_ff, src_in;
   logic [IDX_BITS-1:0]          pos_ff, pos_in;
   logic signed [COUNT_BITS-1:0] new_count_ff, new_count_in;
   logic signed [COUNT_BITS-1:0] prev_count_ff, prev_count_in;
   logic [IDX_BITS-1:0]          run_ff, run_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [FOUND_BITS-1:0]        rsp_found_data_ff, rsp_found_data_in;
   logic                         rsp_replaced_ff, rsp_replaced_in;

   logic                         mem_wr_en;
   logic [IDX_BITS-1:0]          mem_wr_addr;
   logic [KEY_BITS-1:0]          mem_wr_key;
   logic [DATA_BITS-1:0]         mem_wr_data;
   logic signed [COUNT_BITS-1:0] mem_wr_count;
   logic                         mem_rd_en;
   logic [IDX_BITS-1:0]          mem_rd_addr;
   logic [KEY_BITS-1:0]          mem_rd_key;
   logic [DATA_BITS-1:0]         mem_rd_data;
   logic signed [COUNT_BITS-1:0] mem_rd_count;

   logic [IN_WIDE_BITS-1:0]      req_data_wide;
   logic [OUT_WIDE_BITS-1:0]     found_data_wide;
   logic signed [COUNT_BITS-1:0] offered_count;
   logic [IDX_BITS-1:0]          run_cur;

   hcsc_mem #(
      .DEPTH     (CACHE_ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_key   (mem_wr_key),
      .wr_data  (mem_wr_data),
      .wr_count (mem_wr_count),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_key   (mem_rd_key),
      .rd_data  (mem_rd_data),
      .rd_count (mem_rd_count)
   );

   assign req_data_wide   = IN_WIDE_BITS'(req_entry_data);
   assign found_data_wide = OUT_WIDE_BITS'(data_ff);
   assign offered_count   = $signed(COUNT_BITS'(offered_ff));

   // Start of the run of equal counts that holds the entry now being searched.
   // A hit entry below COUNT_MAX moves up to the head of its run: all earlier entries have larger counts.
   assign run_cur = (idx_ff == '0 || mem_rd_count != prev_count_ff) ? idx_ff : run_ff;

   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      op_in             = op_ff;
      key_in            = key_ff;
      data_in           = data_ff;
      offered_in        = offered_ff;
      found_in          = found_ff;
      src_in            = src_ff;
      pos_in            = pos_ff;
      new_count_in      = new_count_ff;
      prev_count_in     = prev_count_ff;
      run_in            = run_ff;
      rsp_valid_in      = 1'b0;
      rsp_hit_in        = rsp_hit_ff;
      rsp_found_data_in = rsp_found_data_ff;
      rsp_replaced_in   = rsp_replaced_ff;

      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_key   = key_ff;
      mem_wr_data  = data_ff;
      mem_wr_count = new_count_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // Empty key, zero data, count minus the entry index
            mem_wr_en    = 1'b1;
            mem_wr_addr  = idx_ff;
            mem_wr_key   = '0;
            mem_wr_data  = '0;
            mem_wr_count = -$signed(COUNT_BITS'(idx_ff));
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in       = op_type'(req_op);
               key_in      = req_key[KEY_BITS-1:0];
               data_in     = req_data_wide[DATA_BITS-1:0];
               offered_in  = req_offered_count;
               found_in    = 1'b0;
               idx_in      = '0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Entry idx_ff is on the read port; fetch the next one meanwhile
            run_in        = run_cur;
            prev_count_in = mem_rd_count;
            if (!found_ff && key_ff != '0) begin
               if (op_ff == OP_LOOKUP) begin
                  if (mem_rd_key == key_ff) begin
                     found_in = 1'b1;
                     src_in   = idx_ff;
                     data_in  = mem_rd_data;
                     if (mem_rd_count == COUNT_MAX) begin
                        pos_in       = idx_ff;
                        new_count_in = mem_rd_count;
                     end else begin
                        pos_in       = run_cur;
                        new_count_in = mem_rd_count + COUNT_ONE;
                     end
                  end
               end else if (mem_rd_count < offered_count) begin
                  // First smaller count is the insert point; the last entry drops out
                  found_in     = 1'b1;
                  pos_in       = idx_ff;
                  src_in       = LAST_IDX;
                  new_count_in = offered_count;
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DECIDE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               rsp_valid_in      = 1'b1;
               rsp_hit_in        = 1'b0;
               rsp_found_data_in = '0;
               rsp_replaced_in   = 1'b0;
               state_in          = ST_IDLE;
            end else if (src_ff == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = src_ff - 1'b1;
               idx_in      = src_ff - 1'b1;
               state_in    = ST_MOVE;
            end
         end
         ST_MOVE: begin
            // Shift entry idx_ff down one place; the write never hits a pending read
            mem_wr_en    = 1'b1;
            mem_wr_addr  = idx_ff + 1'b1;
            mem_wr_key   = mem_rd_key;
            mem_wr_data  = mem_rd_data;
            mem_wr_count = mem_rd_count;
            if (idx_ff == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff - 1'b1;
               idx_in      = idx_ff - 1'b1;
            end
         end
         ST_PLACE: begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = pos_ff;
            mem_wr_key        = key_ff;
            mem_wr_data       = data_ff;
            mem_wr_count      = new_count_ff;
            rsp_valid_in      = 1'b1;
            rsp_hit_in        = (op_ff == OP_LOOKUP);
            rsp_found_data_in = (op_ff == OP_LOOKUP) ? found_data_wide[FOUND_BITS-1:0] : '0;
            rsp_replaced_in   = (op_ff == OP_OFFER);
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      key_ff            <= key_in;
      data_ff           <= data_in;
      offered_ff        <= offered_in;
      src_ff            <= src_in;
      pos_ff            <= pos_in;
      new_count_ff      <= new_count_in;
      prev_count_ff     <= prev_count_in;
      run_ff            <= run_in;
      rsp_hit_ff        <= rsp_hit_in;
      rsp_found_data_ff <= rsp_found_data_in;
      rsp_replaced_ff   <= rsp_replaced_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_found_data = rsp_found_data_ff;
   assign rsp_replaced   = rsp_replaced_ff;

endmodule
